FILE: rtl/corner_point_rect_packer_macros.svh
// ----------------------------------------------------------------------------
// Corner point rectangle packer - assertion macros
// Shared property wrappers clocked on clk and disabled while rst is high.
// ----------------------------------------------------------------------------
`ifndef CORNER_POINT_RECT_PACKER_MACROS_SVH
`define CORNER_POINT_RECT_PACKER_MACROS_SVH

// same-cycle implication
`define CPRP_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define CPRP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

FILE: rtl/cprp_pkg.sv
// ----------------------------------------------------------------------------
// Corner point rectangle packer - package
// Field widths, status codes and the compare unit result type.
// ----------------------------------------------------------------------------
package cprp_pkg;

  localparam int DW    = 11;  // rect_width / rect_height
  localparam int POS_W = 10;  // pos_x / pos_y
  localparam int IN_W  = 24;
  localparam int OUT_W = 24;

  typedef logic [1:0] status_t;

  localparam status_t ST_PLACED = 2'd0;
  localparam status_t ST_NOFIT  = 2'd1;
  localparam status_t ST_FULL   = 2'd2;

  typedef struct packed {
    logic hit;  // box overlaps the placed rectangle
    logic oob;  // box runs past the area edge
  } cmp_res_t;

endpackage

FILE: rtl/cprp_cmp.sv
// ----------------------------------------------------------------------------
// Corner point rectangle packer - shared compare unit
// Overlap test of a box against one placed rectangle plus the area bounds
// check. A 1x1 box turns the overlap test into a point-inside test.
// ----------------------------------------------------------------------------
module cprp_cmp #(
  parameter int AREA_SIZE = 1024,
  parameter int CW        = 11,
  parameter int XW        = 10,
  parameter int SW        = 12
) (
  input  logic [CW-1:0]            x,
  input  logic [CW-1:0]            y,
  input  logic [cprp_pkg::DW-1:0]  w,
  input  logic [cprp_pkg::DW-1:0]  h,
  input  logic [XW-1:0]            rx,
  input  logic [XW-1:0]            ry,
  input  logic [cprp_pkg::DW-1:0]  rw,
  input  logic [cprp_pkg::DW-1:0]  rh,
  output cprp_pkg::cmp_res_t       res
);

  localparam logic [SW-1:0] AREA = SW'(AREA_SIZE);

  logic [SW-1:0] x_end, y_end, r_xend, r_yend;

  always_comb begin
    x_end   = SW'(x) + SW'(w);
    y_end   = SW'(y) + SW'(h);
    r_xend  = SW'(rx) + SW'(rw);
    r_yend  = SW'(ry) + SW'(rh);
    res.hit = (SW'(x) < r_xend) && (SW'(rx) < x_end) &&
              (SW'(y) < r_yend) && (SW'(ry) < y_end);
    res.oob = (x_end > AREA) || (y_end > AREA);
  end

endmodule

FILE: rtl/corner_point_rect_packer.sv
// ----------------------------------------------------------------------------
// Corner point rectangle packer - top level
// Places rectangles at stored candidate corners inside a square area.
// ----------------------------------------------------------------------------
// One request at a time. A request is walked by a sequencer around a single
// compare unit that tests one (corner, placed rectangle) pair per cycle,
// reading both stores through registered reads. A request is rejected up front
// for a full store, a zero size, or an empty corner list once rectangles are
// placed; a first rectangle that runs past the area is rejected after its test.
// The corner search tries (corner, rectangle) pairs, up to corners x
// rectangles of them, and a failed search then goes to the hand-off. A
// placement runs the search (the first rectangle is tested at the origin only),
// then appends up to four candidate corners for the first rectangle or two
// otherwise, then prunes covered corners, then hands off the result. A result
// still waiting on the output stalls the hand-off.
// The stores need no clearing after reset.
module corner_point_rect_packer #(
  parameter int AREA_SIZE   = 1024,
  parameter int MAX_RECTS   = 64,
  parameter int MAX_CORNERS = 128
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       s_tvalid,
  output logic                       s_tready,
  input  logic [cprp_pkg::IN_W-1:0]  s_tdata,   // rect_width[10:0], rect_height[21:11]
  output logic                       m_tvalid,
  input  logic                       m_tready,
  output logic [cprp_pkg::OUT_W-1:0] m_tdata    // status[1:0], pos_x[11:2], pos_y[21:12]
);

  localparam int DW   = cprp_pkg::DW;
  localparam int XW   = $clog2(AREA_SIZE);
  localparam int CW   = $clog2(AREA_SIZE + 2);
  localparam int SW   = ((CW > DW) ? CW : DW) + 1;
  localparam int RAW  = (MAX_RECTS > 1) ? $clog2(MAX_RECTS) : 1;
  localparam int RCW  = $clog2(MAX_RECTS + 1);
  localparam int CAW  = $clog2(MAX_CORNERS);
  localparam int CCW  = $clog2(MAX_CORNERS + 1);
  localparam int RE_W = 2 * XW + 2 * DW;
  localparam int CE_W = 2 * CW;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_FIRST = 3'd1;
  localparam logic [2:0] S_SCAN  = 3'd2;
  localparam logic [2:0] S_APP   = 3'd3;
  localparam logic [2:0] S_PRUNE = 3'd4;
  localparam logic [2:0] S_DONE  = 3'd5;

  logic [2:0]     state, state_next;
  logic [DW-1:0]  w_r, h_r;
  logic [RCW-1:0] rect_count, rect_count_next;
  logic [CCW-1:0] corner_count, corner_count_next;
  logic [CCW-1:0] ci, ci_next;
  logic [CCW-1:0] kk, kk_next;
  logic [RCW-1:0] rj, rj_next;
  logic [1:0]     app, app_next;
  logic [CW-1:0]  px, px_next, py, py_next;
  cprp_pkg::status_t res_st, res_st_next;

  logic [RE_W-1:0] rmem [MAX_RECTS];
  logic [CE_W-1:0] cmem [MAX_CORNERS];
  logic [RE_W-1:0] rect_q;
  logic [CE_W-1:0] corner_q;

  logic            r_we, c_we;
  logic [CAW-1:0]  c_waddr;
  logic [CE_W-1:0] c_wdata;

  logic                out_valid;
  cprp_pkg::status_t   out_st;
  logic [cprp_pkg::POS_W-1:0] out_x, out_y;

  logic               accept;
  logic [CW-1:0]      cq_x, cq_y, u_x, u_y;
  logic [DW-1:0]      u_w, u_h;
  cprp_pkg::cmp_res_t cmp;
  logic [SW-1:0]      w_inc, h_inc, sum_xw, sum_yh, px_ext, py_ext;
  logic [CW-1:0]      ax, ay;
  logic               a_ok;

  assign s_tready = (state == S_IDLE);
  assign accept   = s_tvalid && s_tready;
  assign cq_x     = corner_q[CE_W-1 -: CW];
  assign cq_y     = corner_q[CW-1:0];

  // the first rectangle is tested at the origin, pruning uses a 1x1 box
  assign u_x = (state == S_FIRST) ? '0 : cq_x;
  assign u_y = (state == S_FIRST) ? '0 : cq_y;
  assign u_w = (state == S_PRUNE) ? DW'(1) : w_r;
  assign u_h = (state == S_PRUNE) ? DW'(1) : h_r;

  cprp_cmp #(
    .AREA_SIZE (AREA_SIZE),
    .CW        (CW),
    .XW        (XW),
    .SW        (SW)
  ) u_cmp (
    .x   (u_x),
    .y   (u_y),
    .w   (u_w),
    .h   (u_h),
    .rx  (rect_q[RE_W-1 -: XW]),
    .ry  (rect_q[2*DW+XW-1 -: XW]),
    .rw  (rect_q[2*DW-1 -: DW]),
    .rh  (rect_q[DW-1:0]),
    .res (cmp)
  );

  // corner candidates appended after a placement
  always_comb begin
    w_inc  = SW'(w_r) + SW'(1);
    h_inc  = SW'(h_r) + SW'(1);
    sum_xw = SW'(px) + SW'(w_r);
    sum_yh = SW'(py) + SW'(h_r);
    unique case (app)
      2'd0: begin
        ax = w_inc[CW-1:0]; ay = '0; a_ok = 1'b1;
      end
      2'd1: begin
        ax = '0; ay = h_inc[CW-1:0]; a_ok = 1'b1;
      end
      2'd2: begin
        ax = sum_xw[CW-1:0]; ay = py; a_ok = (sum_xw < SW'(AREA_SIZE));
      end
      default: begin
        ax = px; ay = sum_yh[CW-1:0]; a_ok = (sum_yh < SW'(AREA_SIZE));
      end
    endcase
  end

  always_comb begin
    state_next        = state;
    rect_count_next   = rect_count;
    corner_count_next = corner_count;
    ci_next           = ci;
    kk_next           = kk;
    rj_next           = rj;
    app_next          = app;
    px_next           = px;
    py_next           = py;
    res_st_next       = res_st;
    r_we              = 1'b0;
    c_we              = 1'b0;
    c_waddr           = corner_count[CAW-1:0];
    c_wdata           = {ax, ay};
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          ci_next     = '0;
          rj_next     = '0;
          px_next     = '0;
          py_next     = '0;
          res_st_next = cprp_pkg::ST_NOFIT;
          if (rect_count == RCW'(MAX_RECTS)) begin
            res_st_next = cprp_pkg::ST_FULL;
            state_next  = S_DONE;
          end else if (s_tdata[DW-1:0] == '0 || s_tdata[2*DW-1:DW] == '0) begin
            state_next = S_DONE;
          end else if (rect_count == '0 && corner_count == '0) begin
            state_next = S_FIRST;
          end else if (corner_count == '0) begin
            state_next = S_DONE;
          end else begin
            state_next = S_SCAN;
          end
        end
      end
      S_FIRST: begin
        if (cmp.oob) begin
          state_next = S_DONE;
        end else begin
          r_we            = 1'b1;
          rect_count_next = rect_count + RCW'(1);
          app_next        = 2'd0;
          state_next      = S_APP;
        end
      end
      S_SCAN: begin
        if (cmp.oob || cmp.hit) begin
          rj_next = '0;
          if (ci + CCW'(1) == corner_count) begin
            state_next = S_DONE;
          end else begin
            ci_next = ci + CCW'(1);
          end
        end else if (rj + RCW'(1) == rect_count) begin
          px_next         = cq_x;
          py_next         = cq_y;
          r_we            = 1'b1;
          rect_count_next = rect_count + RCW'(1);
          app_next        = 2'd2;
          state_next      = S_APP;
        end else begin
          rj_next = rj + RCW'(1);
        end
      end
      S_APP: begin
        if (a_ok && corner_count != CCW'(MAX_CORNERS)) begin
          c_we              = 1'b1;
          corner_count_next = corner_count + CCW'(1);
        end
        app_next = app + 2'd1;
        if (app == 2'd3) begin
          ci_next    = '0;
          rj_next    = '0;
          kk_next    = '0;
          state_next = S_PRUNE;
        end
      end
      S_PRUNE: begin
        c_waddr = kk[CAW-1:0];
        c_wdata = corner_q;
        if (ci == corner_count) begin
          corner_count_next = kk;
          res_st_next       = cprp_pkg::ST_PLACED;
          state_next        = S_DONE;
        end else if (cmp.hit) begin
          ci_next = ci + CCW'(1);
          rj_next = '0;
        end else if (rj + RCW'(1) == rect_count) begin
          c_we    = 1'b1;   // keep corner, compact toward the front
          kk_next = kk + CCW'(1);
          ci_next = ci + CCW'(1);
          rj_next = '0;
        end else begin
          rj_next = rj + RCW'(1);
        end
      end
      S_DONE: begin
        if (!out_valid || m_tready) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      rect_count   <= '0;
      corner_count <= '0;
    end else begin
      state        <= state_next;
      rect_count   <= rect_count_next;
      corner_count <= corner_count_next;
    end
  end

  always_ff @(posedge clk) begin
    ci     <= ci_next;
    kk     <= kk_next;
    rj     <= rj_next;
    app    <= app_next;
    px     <= px_next;
    py     <= py_next;
    res_st <= res_st_next;
    if (accept) begin
      w_r <= s_tdata[DW-1:0];
      h_r <= s_tdata[2*DW-1:DW];
    end
  end

  // stores: one write port, registered read that follows the next index
  always_ff @(posedge clk) begin
    if (r_we) begin
      rmem[rect_count[RAW-1:0]] <= {px_next[XW-1:0], py_next[XW-1:0], w_r, h_r};
    end
    rect_q <= rmem[rj_next[RAW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (c_we) begin
      cmem[c_waddr] <= c_wdata;
    end
    corner_q <= cmem[ci_next[CAW-1:0]];
  end

  assign px_ext = SW'(px);
  assign py_ext = SW'(py);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_DONE && (!out_valid || m_tready)) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_DONE && (!out_valid || m_tready)) begin
      out_st <= res_st;
      out_x  <= px_ext[cprp_pkg::POS_W-1:0];
      out_y  <= py_ext[cprp_pkg::POS_W-1:0];
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {2'b00, out_y, out_x, out_st};

`include "corner_point_rect_packer_macros.svh"

  `CPRP_ASSERT_NOW(a_rect_bound, 1'b1, rect_count <= RCW'(MAX_RECTS), "rect count overflow")
  `CPRP_ASSERT_NOW(a_corner_bound, 1'b1, corner_count <= CCW'(MAX_CORNERS), "corner count overflow")
  `CPRP_ASSERT_NEXT(a_busy, accept, state != S_IDLE, "accepted request did not start")
  `CPRP_ASSERT_NOW(a_zero_pos, m_tvalid && m_tdata[1:0] != cprp_pkg::ST_PLACED, m_tdata[21:2] == '0, "rejected request has nonzero position")

endmodule

FILE: tb/sv/testbench.sv
// ----------------------------------------------------------------------------
// Corner point rectangle packer - testbench
// Drives placement requests over the input stream and checks every result on
// the output stream against a behavioral packer kept in a scoreboard class.
// ----------------------------------------------------------------------------
module testbench;

  localparam int AREA  = 1024;
  localparam int NRECT = 64;
  localparam int NCORN = 128;
  localparam int WATCHDOG_LIMIT = 200000;

  // first member sits in the high bits: pos_y, pos_x, status from the top down
  typedef struct packed {
    logic [cprp_pkg::POS_W-1:0] pos_y;
    logic [cprp_pkg::POS_W-1:0] pos_x;
    cprp_pkg::status_t          status;
  } placement_t;

  class packer_scoreboard;
    int unsigned rx[NRECT], ry[NRECT], rw[NRECT], rh[NRECT];
    int unsigned cx[NCORN], cy[NCORN];
    int unsigned rect_cnt, corner_cnt;
    placement_t pending[$];
    int errors, placed, nofit, full;

    function void clear();
      rect_cnt = 0;
      corner_cnt = 0;
    endfunction

    function void push_corner(int unsigned x, int unsigned y);
      if (corner_cnt < NCORN) begin
        cx[corner_cnt] = x;
        cy[corner_cnt] = y;
        corner_cnt++;
      end
    endfunction

    function bit box_free(int unsigned x, int unsigned y, int unsigned w, int unsigned h);
      if (x + w - 1 >= AREA || y + h - 1 >= AREA) return 0;
      for (int i = 0; i < rect_cnt; i++)
        if (x < rx[i] + rw[i] && rx[i] < x + w && y < ry[i] + rh[i] && ry[i] < y + h)
          return 0;
      return 1;
    endfunction

    // near edges count as inside, far edges do not, so corners touching a far edge are kept
    function void drop_covered_corners();
      int unsigned k;
      bit covered;
      k = 0;
      for (int i = 0; i < corner_cnt; i++) begin
        covered = 0;
        for (int j = 0; j < rect_cnt; j++)
          if (cx[i] >= rx[j] && cx[i] < rx[j] + rw[j] &&
              cy[i] >= ry[j] && cy[i] < ry[j] + rh[j]) covered = 1;
        if (!covered) begin
          cx[k] = cx[i];
          cy[k] = cy[i];
          k++;
        end
      end
      corner_cnt = k;
    endfunction

    function void note_request(logic [cprp_pkg::DW-1:0] w_in, logic [cprp_pkg::DW-1:0] h_in);
      int unsigned w, h, px, py;
      bit ok;
      placement_t p;
      w = w_in;
      h = h_in;
      px = 0;
      py = 0;
      ok = 0;
      p.status = cprp_pkg::ST_NOFIT;
      if (rect_cnt >= NRECT) p.status = cprp_pkg::ST_FULL;
      else if (w != 0 && h != 0) begin
        if (rect_cnt == 0 && corner_cnt == 0) begin
          if (box_free(0, 0, w, h)) begin
            ok = 1;
            push_corner(w + 1, 0);
            push_corner(0, h + 1);
          end
        end else begin
          for (int i = 0; i < corner_cnt && !ok; i++)
            if (box_free(cx[i], cy[i], w, h)) begin
              px = cx[i];
              py = cy[i];
              ok = 1;
            end
        end
        if (ok) begin
          rx[rect_cnt] = px;
          ry[rect_cnt] = py;
          rw[rect_cnt] = w;
          rh[rect_cnt] = h;
          rect_cnt++;
          if (px + w < AREA) push_corner(px + w, py);
          if (py + h < AREA) push_corner(px, py + h);
          p.status = cprp_pkg::ST_PLACED;
        end
      end
      drop_covered_corners();
      p.pos_x = ok ? px[cprp_pkg::POS_W-1:0] : '0;
      p.pos_y = ok ? py[cprp_pkg::POS_W-1:0] : '0;
      pending.push_back(p);
    endfunction

    function void check_result(logic [cprp_pkg::OUT_W-1:0] data);
      placement_t got, exp;
      got = data[21:0];
      if (pending.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %h", $time, got);
        errors++;
        return;
      end
      exp = pending.pop_front();
      unique case (got.status)
        cprp_pkg::ST_PLACED: placed++;
        cprp_pkg::ST_FULL:   full++;
        default:             nofit++;
      endcase
      if (got.status !== exp.status) begin
        $display("%0t: status mismatch, expected %0d, actual %0d", $time, exp.status, got.status);
        errors++;
      end
      if (got.pos_x !== exp.pos_x) begin
        $display("%0t: pos_x mismatch, expected %0d, actual %0d", $time, exp.pos_x, got.pos_x);
        errors++;
      end
      if (got.pos_y !== exp.pos_y) begin
        $display("%0t: pos_y mismatch, expected %0d, actual %0d", $time, exp.pos_y, got.pos_y);
        errors++;
      end
      if (data[cprp_pkg::OUT_W-1:22] !== '0) begin
        $display("%0t: pad bits, expected 0, actual %h", $time, data[cprp_pkg::OUT_W-1:22]);
        errors++;
      end
    endfunction
  endclass

  logic clk, rst;
  logic s_tvalid, s_tready, m_tvalid, m_tready;
  logic [cprp_pkg::IN_W-1:0] s_tdata;
  logic [cprp_pkg::OUT_W-1:0] m_tdata;
  bit calm;  // long stretch with no idling on either side
  int idle_cycles;
  packer_scoreboard board;

  corner_point_rect_packer DUT (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  always @(posedge clk) begin
    if (rst) m_tready <= 1'b0;
    else m_tready <= calm || ($urandom_range(99) >= 14);
    if (!rst && m_tvalid && m_tready) board.check_result(m_tdata);
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("testbench NOT OK");
      $finish;
    end
  end

  // valid stays up from one request to the next unless an idle cycle is drawn
  task automatic send_request(int unsigned w, int unsigned h);
    while (!calm && $urandom_range(99) < 14) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {2'b00, h[cprp_pkg::DW-1:0], w[cprp_pkg::DW-1:0]};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    board.note_request(w[cprp_pkg::DW-1:0], h[cprp_pkg::DW-1:0]);
  endtask

  // mix of small, large, oversize and tiny requests
  task automatic random_request();
    int unsigned sel;
    sel = $urandom_range(99);
    if (sel < 60) send_request($urandom_range(160, 1), $urandom_range(160, 1));
    else if (sel < 80) send_request($urandom_range(1024, 1), $urandom_range(1024, 1));
    else if (sel < 90) send_request($urandom_range(2047), $urandom_range(2047));
    else send_request($urandom_range(8, 1), $urandom_range(8, 1));
  endtask

  initial begin
    board = new();
    board.clear();
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    calm = 1'b0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    // first rectangle too large for the area, zero sizes, then exact fits
    send_request(1025, 4);
    send_request(0, 5);
    send_request(5, 0);
    send_request(0, 0);
    send_request(2047, 2047);
    send_request(1, 1);
    send_request(1022, 1);
    send_request(1, 1022);
    send_request(1024, 1024);
    send_request(1, 1);
    send_request(2, 1);
    send_request(1, 2);
    send_request(1023, 1);
    for (int i = 0; i < 50; i++) begin
      calm = (i >= 10 && i < 30);
      random_request();
    end
    calm = 1'b0;
    // tiny boxes fill the store and then hit the store-full path
    for (int i = 0; i < 70; i++) send_request($urandom_range(3, 1), $urandom_range(3, 1));
    for (int i = 0; i < 20; i++) random_request();
    s_tvalid <= 1'b0;
    while (board.pending.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    $display("covered %0d placed, %0d without fit, %0d with full store",
             board.placed, board.nofit, board.full);
    if (board.errors == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end
endmodule
